// File: rtl/core/nec_pkg.sv
// Shared types, constants and the window-check function for the NEC IR frame decoder.
package nec_pkg;

  localparam int TICK_W   = 15;
  localparam int MARGIN_W = 12;
  localparam int COUNT_W  = 6;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 3;
  localparam int ERR_W    = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] FRAME_SYMBOLS  = COUNT_W'(34);
  localparam logic [COUNT_W-1:0] REPEAT_SYMBOLS = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = COUNT_W'(63);
  localparam logic [COUNT_W-1:0] LAST_BIT_SYM   = COUNT_W'(32);
  localparam logic [COUNT_W-1:0] CMD_FIRST_SYM  = COUNT_W'(17);

  // first-error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEADER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BIT    = 2'd2;

  // frame status codes
  localparam logic [STATUS_W-1:0] ST_VALID  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPEAT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COUNT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEADER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BIT    = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 8'd6;

  // config reset values
  localparam logic [MARGIN_W-1:0] RST_MARGIN       = 12'd200;
  localparam logic [TICK_W-1:0]   RST_LEADER_MARK  = 15'd9000;
  localparam logic [TICK_W-1:0]   RST_LEADER_SPACE = 15'd4500;
  localparam logic [TICK_W-1:0]   RST_ZERO_MARK    = 15'd560;
  localparam logic [TICK_W-1:0]   RST_ZERO_SPACE   = 15'd560;
  localparam logic [TICK_W-1:0]   RST_ONE_MARK     = 15'd560;
  localparam logic [TICK_W-1:0]   RST_ONE_SPACE    = 15'd1690;

  typedef struct packed {
    logic [TICK_W-1:0] mark_ticks;
    logic [TICK_W-1:0] space_ticks;
    logic              end_of_frame;
  } nec_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] frame_status;
    logic [WORD_W-1:0]   address;
    logic [WORD_W-1:0]   command_code;
  } nec_out_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] decode_margin;
    logic [TICK_W-1:0]   leader_mark;
    logic [TICK_W-1:0]   leader_space;
    logic [TICK_W-1:0]   zero_mark;
    logic [TICK_W-1:0]   zero_space;
    logic [TICK_W-1:0]   one_mark;
    logic [TICK_W-1:0]   one_space;
  } nec_cfg_t;

  typedef struct packed {
    logic leader_ok;
    logic one_ok;
    logic zero_ok;
  } nec_class_t;

  // strict window: lo < d < hi, lo clamped at zero
  function automatic logic in_window(input logic [TICK_W-1:0]   d,
                                     input logic [TICK_W-1:0]   nom,
                                     input logic [MARGIN_W-1:0] margin);
    logic [TICK_W:0]   hi;
    logic [TICK_W-1:0] lo;
    logic [TICK_W-1:0] margin_x;
    margin_x = TICK_W'(margin);
    hi = {1'b0, nom} + {1'b0, margin_x};
    lo = (nom > margin_x) ? (nom - margin_x) : '0;
    return ({1'b0, d} < hi) && (d > lo);
  endfunction

endpackage

// File: rtl/core/nec_sym_class.sv
// Symbol classifier: leader / logic-one / logic-zero window checks.
module nec_sym_class (
  input  nec_pkg::nec_in_t    sym,
  input  nec_pkg::nec_cfg_t   cfg,
  output nec_pkg::nec_class_t cls
);
  import nec_pkg::*;

  always_comb begin
    cls.leader_ok = in_window(sym.mark_ticks, cfg.leader_mark, cfg.decode_margin) &&
                    in_window(sym.space_ticks, cfg.leader_space, cfg.decode_margin);
    cls.one_ok    = in_window(sym.mark_ticks, cfg.one_mark, cfg.decode_margin) &&
                    in_window(sym.space_ticks, cfg.one_space, cfg.decode_margin);
    cls.zero_ok   = in_window(sym.mark_ticks, cfg.zero_mark, cfg.decode_margin) &&
                    in_window(sym.space_ticks, cfg.zero_space, cfg.decode_margin);
  end

endmodule

// File: rtl/core/nec_frame_acc.sv
// Frame accumulator: symbol count, address/command shift words, first error, result.
module nec_frame_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sym_adv,
  input  logic                sym_eof,
  input  nec_pkg::nec_class_t cls,
  output nec_pkg::nec_out_t   res
);
  import nec_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;
  logic [WORD_W-1:0]  addr_r, addr_nxt, addr_upd;
  logic [WORD_W-1:0]  cmd_r, cmd_nxt, cmd_upd;
  logic [ERR_W-1:0]   err_r, err_nxt, err_upd;
  logic [COUNT_W-1:0] bit_idx;
  logic               bit_ok;

  always_comb begin
    err_upd  = err_r;
    addr_upd = addr_r;
    cmd_upd  = cmd_r;
    bit_idx  = count_r - COUNT_W'(1);
    bit_ok   = cls.one_ok || cls.zero_ok;
    if (count_r == '0) begin
      if (!cls.leader_ok && err_r == ERR_NONE) begin
        err_upd = ERR_LEADER;
      end
    end else if (count_r <= LAST_BIT_SYM) begin
      if (!bit_ok && err_r == ERR_NONE) begin
        err_upd = ERR_BIT;
      end
      if (cls.one_ok) begin
        if (count_r < CMD_FIRST_SYM) begin
          addr_upd[bit_idx[3:0]] = 1'b1;
        end else begin
          cmd_upd[bit_idx[3:0]] = 1'b1;
        end
      end
    end
    count_inc = (count_r < COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;

    res.frame_status = ST_COUNT;
    res.address      = '0;
    res.command_code = '0;
    if (count_inc == FRAME_SYMBOLS) begin
      case (err_upd)
        ERR_LEADER: res.frame_status = ST_LEADER;
        ERR_BIT:    res.frame_status = ST_BIT;
        default: begin
          res.frame_status = ST_VALID;
          res.address      = addr_upd;
          res.command_code = cmd_upd;
        end
      endcase
    end else if (count_inc == REPEAT_SYMBOLS) begin
      res.frame_status = ST_REPEAT;
    end

    count_nxt = count_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    err_nxt   = err_r;
    if (sym_adv) begin
      if (sym_eof) begin
        count_nxt = '0;
        addr_nxt  = '0;
        cmd_nxt   = '0;
        err_nxt   = ERR_NONE;
      end else begin
        count_nxt = count_inc;
        addr_nxt  = addr_upd;
        cmd_nxt   = cmd_upd;
        err_nxt   = err_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      addr_r  <= '0;
      cmd_r   <= '0;
      err_r   <= ERR_NONE;
    end else begin
      count_r <= count_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      err_r   <= err_nxt;
    end
  end

  // count only moves forward by one, holds at saturation, or restarts at frame end
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    sym_adv && !sym_eof && count_r != COUNT_MAX |=> count_r == $past(count_r) + COUNT_W'(1))
    else $error("symbol count did not advance");

  // an error once recorded is never overwritten within a frame
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sym_adv && !sym_eof && err_r != ERR_NONE |=> err_r == $past(err_r))
    else $error("first error overwritten");

  // shift words stay empty until the first data symbol is processed
  a_shift_empty: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(1) |-> addr_r == '0 && cmd_r == '0)
    else $error("shift words not clear at frame start");

endmodule

// File: rtl/core/nec_ir_frame_decoder_top.sv
// Top level of the NEC IR frame decoder: config registers, symbol register, result register.
// Path: a symbol accepted into the symbol register is classified from it combinationally;
//   its frame result (end-of-frame symbols only) is loaded into the result register and shows on out_*.
// Throughput: one symbol per cycle; the symbol register and result register decouple
//   the channels, so only a stalled result with an end-of-frame symbol behind it blocks input.
// Reset (rst_n low, synchronous): frame state cleared, config back to NEC defaults
//   (margin 200, leader 9000/4500, zero 560/560, one 560/1690); no clearing pass.
module nec_ir_frame_decoder_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // symbol channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  nec_pkg::nec_in_t                 in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output nec_pkg::nec_out_t                out_data,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nec_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import nec_pkg::*;

  // config registers
  nec_cfg_t   cfg_r, cfg_nxt;

  // symbol register stage
  logic       sym_valid_r, sym_valid_nxt;
  nec_in_t    sym_r, sym_nxt;

  // result register stage
  logic       res_valid_r, res_valid_nxt;
  nec_out_t   res_r, res_nxt;

  nec_class_t cls;
  nec_out_t   frame_res;
  logic       res_free;
  logic       sym_adv;
  logic       in_acc;

  // cfg writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MARGIN:       cfg_nxt.decode_margin = cfg_data[MARGIN_W-1:0];
        REG_LEADER_MARK:  cfg_nxt.leader_mark   = cfg_data[TICK_W-1:0];
        REG_LEADER_SPACE: cfg_nxt.leader_space  = cfg_data[TICK_W-1:0];
        REG_ZERO_MARK:    cfg_nxt.zero_mark     = cfg_data[TICK_W-1:0];
        REG_ZERO_SPACE:   cfg_nxt.zero_space    = cfg_data[TICK_W-1:0];
        REG_ONE_MARK:     cfg_nxt.one_mark      = cfg_data[TICK_W-1:0];
        REG_ONE_SPACE:    cfg_nxt.one_space     = cfg_data[TICK_W-1:0];
        default:          cfg_nxt               = cfg_r;
      endcase
    end
  end

  // classify the held symbol against the timing windows
  nec_sym_class u_class (
    .sym (sym_r),
    .cfg (cfg_r),
    .cls (cls)
  );

  // frame state advances when the held symbol is consumed
  nec_frame_acc u_frame (
    .clk     (clk),
    .rst_n   (rst_n),
    .sym_adv (sym_adv),
    .sym_eof (sym_r.end_of_frame),
    .cls     (cls),
    .res     (frame_res)
  );

  // handshake: a non-final symbol always moves on; a final one needs a free result slot
  assign res_free = !res_valid_r || out_ready;
  assign sym_adv  = sym_valid_r && (!sym_r.end_of_frame || res_free);
  assign in_ready = !sym_valid_r || sym_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    sym_valid_nxt = sym_valid_r;
    sym_nxt       = sym_r;
    if (in_acc) begin
      sym_valid_nxt = 1'b1;
      sym_nxt       = in_data;
    end else if (sym_adv) begin
      sym_valid_nxt = 1'b0;
    end

    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    if (sym_adv && sym_r.end_of_frame) begin
      res_valid_nxt = 1'b1;
      res_nxt       = frame_res;
    end else if (out_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decode_margin <= RST_MARGIN;
      cfg_r.leader_mark   <= RST_LEADER_MARK;
      cfg_r.leader_space  <= RST_LEADER_SPACE;
      cfg_r.zero_mark     <= RST_ZERO_MARK;
      cfg_r.zero_space    <= RST_ZERO_SPACE;
      cfg_r.one_mark      <= RST_ONE_MARK;
      cfg_r.one_space     <= RST_ONE_SPACE;
      sym_valid_r         <= 1'b0;
      res_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      sym_valid_r <= sym_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = res_valid_r;
  assign out_data  = res_r;

  // status code always one of the defined outcomes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> res_r.frame_status <= ST_BIT)
    else $error("result status out of range");

  // decoded words only accompany a valid frame
  a_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.frame_status != ST_VALID |->
      res_r.address == '0 && res_r.command_code == '0)
    else $error("address/command set on a failed frame");

  // a final symbol blocked by a stalled result is kept, not dropped
  a_eof_held: assert property (@(posedge clk) disable iff (!rst_n)
    sym_valid_r && sym_r.end_of_frame && !res_free |=>
      sym_valid_r && sym_r.end_of_frame)
    else $error("final symbol lost while result stalled");

  // a new result is only loaded into a free slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !out_ready |=> res_valid_r && res_r == $past(res_r))
    else $error("pending result overwritten");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the NEC IR frame decoder: directed and random symbol streams.
`timescale 1ns / 100ps

module testbench;
  import nec_pkg::*;

  localparam int TICK_MAX     = (1 << TICK_W) - 1;
  localparam int MARGIN_MAX   = (1 << MARGIN_W) - 1;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int SETTLE       = 8;       // symbol reg + result reg, with slack
  localparam int DRAIN_LIMIT  = 20000;
  localparam int RUN_LIMIT_NS = 5000000;

  typedef enum int {FK_CLEAN, FK_BAD_LEADER, FK_BAD_BIT, FK_ODD_LENGTH, FK_REPEAT} frame_kind_t;

  // Frame predictor plus the queue of frame results still owed by the block.
  class frame_result_board;
    nec_cfg_t           regs;
    logic [COUNT_W-1:0] sym_count;
    logic [WORD_W-1:0]  addr_bits;
    logic [WORD_W-1:0]  cmd_bits;
    logic [ERR_W-1:0]   first_err;
    nec_out_t           due_results[$];
    int                 errors;

    function new();
      regs.decode_margin = RST_MARGIN;
      regs.leader_mark   = RST_LEADER_MARK;
      regs.leader_space  = RST_LEADER_SPACE;
      regs.zero_mark     = RST_ZERO_MARK;
      regs.zero_space    = RST_ZERO_SPACE;
      regs.one_mark      = RST_ONE_MARK;
      regs.one_space     = RST_ONE_SPACE;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      sym_count = '0;
      addr_bits = '0;
      cmd_bits  = '0;
      first_err = ERR_NONE;
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MARGIN:       regs.decode_margin = data[MARGIN_W-1:0];
        REG_LEADER_MARK:  regs.leader_mark   = data[TICK_W-1:0];
        REG_LEADER_SPACE: regs.leader_space  = data[TICK_W-1:0];
        REG_ZERO_MARK:    regs.zero_mark     = data[TICK_W-1:0];
        REG_ZERO_SPACE:   regs.zero_space    = data[TICK_W-1:0];
        REG_ONE_MARK:     regs.one_mark      = data[TICK_W-1:0];
        REG_ONE_SPACE:    regs.one_space     = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // open window: nom - margin < d < nom + margin, lower edge floored at zero
    function bit passes_window(logic [TICK_W-1:0] d, logic [TICK_W-1:0] nom);
      int unsigned dv, nv, m, top, bot;
      dv = 32'(d);
      nv = 32'(nom);
      m = 32'(regs.decode_margin);
      top = nv + m;
      bot = (nv > m) ? nv - m : 0;
      return (dv < top) && (dv > bot);
    endfunction

    function void take_symbol(nec_in_t s);
      nec_out_t res;
      int       pos;
      bit       is_one;
      bit       is_zero;
      if (sym_count == 0) begin
        if (!(passes_window(s.mark_ticks, regs.leader_mark) &&
              passes_window(s.space_ticks, regs.leader_space)) && first_err == ERR_NONE)
          first_err = ERR_LEADER;
      end else if (sym_count <= LAST_BIT_SYM) begin
        pos = sym_count - 1;
        is_one  = passes_window(s.mark_ticks, regs.one_mark) &&
                  passes_window(s.space_ticks, regs.one_space);
        is_zero = passes_window(s.mark_ticks, regs.zero_mark) &&
                  passes_window(s.space_ticks, regs.zero_space);
        if (is_one) begin
          if (pos < WORD_W) addr_bits[pos] = 1'b1;
          else cmd_bits[pos - WORD_W] = 1'b1;
        end else if (!is_zero && first_err == ERR_NONE) begin
          first_err = ERR_BIT;
        end
      end
      if (sym_count != COUNT_MAX) sym_count++;
      if (!s.end_of_frame) return;
      res = '0;
      if (sym_count == FRAME_SYMBOLS) begin
        case (first_err)
          ERR_LEADER: res.frame_status = ST_LEADER;
          ERR_BIT:    res.frame_status = ST_BIT;
          default: begin
            res.frame_status = ST_VALID;
            res.address      = addr_bits;
            res.command_code = cmd_bits;
          end
        endcase
      end else if (sym_count == REPEAT_SYMBOLS) begin
        res.frame_status = ST_REPEAT;
      end else begin
        res.frame_status = ST_COUNT;
      end
      due_results.push_back(res);
      clear_frame();
    endfunction

    task check_result(nec_out_t got);
      nec_out_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with none pending: status %0d", got.frame_status));
        return;
      end
      want = due_results.pop_front();
      if (got.frame_status !== want.frame_status)
        report($sformatf("frame_status %0d, want %0d", got.frame_status, want.frame_status));
      if (got.address !== want.address)
        report($sformatf("address %h, want %h", got.address, want.address));
      if (got.command_code !== want.command_code)
        report($sformatf("command_code %h, want %h", got.command_code, want.command_code));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  nec_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  nec_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  frame_result_board board;
  bit tx_idle  = 1'b0;     // sender inserts gaps, 69 in 100 (31 when both sides idle)
  bit rx_stall = 1'b0;     // receiver drops ready, 69 in 100 (31 when both sides idle)
  bit hold_req = 1'b0;     // asks the receiver for one long hold-off
  int sent_count = 0;

  nec_ir_frame_decoder_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: ready changes on the falling edge only. A hold request turns
  // into a fixed run of low-ready cycles so the block backs up into its input.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_stall) begin
        out_ready <= ($urandom_range(99) >= (tx_idle ? 31 : 69));
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every accepted result is checked at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // Called and returns on a falling edge; valid is left high for back-to-back items.
  task automatic send_symbol(int mark, int space, bit eof);
    nec_in_t sym;
    sym.mark_ticks   = TICK_W'(mark);
    sym.space_ticks  = TICK_W'(space);
    sym.end_of_frame = eof;
    if (tx_idle) begin
      while ($urandom_range(99) < (rx_stall ? 31 : 69)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= sym;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_symbol(sym);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.store_reg(idx, data);
    @(negedge clk);
  endtask

  // Unused upper data bits get random junk; the block must drop them.
  task automatic load_config(int margin, int lm, int ls, int zm, int zs, int om, int os);
    write_reg(REG_MARGIN,       {4'($urandom_range(15)), 12'(margin)});
    write_reg(REG_LEADER_MARK,  {1'($urandom_range(1)), 15'(lm)});
    write_reg(REG_LEADER_SPACE, {1'($urandom_range(1)), 15'(ls)});
    write_reg(REG_ZERO_MARK,    {1'($urandom_range(1)), 15'(zm)});
    write_reg(REG_ZERO_SPACE,   {1'($urandom_range(1)), 15'(zs)});
    write_reg(REG_ONE_MARK,     {1'($urandom_range(1)), 15'(om)});
    write_reg(REG_ONE_SPACE,    {1'($urandom_range(1)), 15'(os)});
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every owed result is back, then let the pipeline settle.
  task automatic drain_block();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (board.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int wild_ticks();
    case ($urandom_range(7))
      0: return 0;
      1: return TICK_MAX;
      default: return $urandom_range(TICK_MAX);
    endcase
  endfunction

  // Duration inside the open window around nom; now and then exactly on or
  // next to a window edge, which lands on either side of the check.
  function automatic int near_nom(int nom);
    int m, top, bot, lo_ok, hi_ok, v;
    m = int'(board.regs.decode_margin);
    top = nom + m;
    bot = (nom > m) ? nom - m : 0;
    lo_ok = bot + 1;
    hi_ok = (top - 1 > TICK_MAX) ? TICK_MAX : top - 1;
    if ($urandom_range(127) == 0) begin
      case ($urandom_range(3))
        0: v = bot;
        1: v = bot + 1;
        2: v = top - 1;
        default: v = top;
      endcase
    end else if (lo_ok <= hi_ok) begin
      v = $urandom_range(hi_ok, lo_ok);
    end else begin
      v = nom;   // empty window (zero margin): cannot pass
    end
    if (v < 0) v = 0;
    if (v > TICK_MAX) v = TICK_MAX;
    return v;
  endfunction

  // One frame of the given kind; the last symbol always carries end_of_frame.
  // forced_len of zero picks the length from the kind.
  task automatic send_frame(frame_kind_t kind, int forced_len);
    nec_cfg_t c;
    int       len, bad_pos, k, mark, space;
    bit       one_bit;
    c = board.regs;
    len = 34;
    if (kind == FK_REPEAT) begin
      len = 2;
    end else if (kind == FK_ODD_LENGTH) begin
      case ($urandom_range(3))
        0: len = 1;
        1: len = $urandom_range(33, 3);
        2: len = $urandom_range(70, 35);   // past 63 the count saturates
        default: len = ($urandom_range(1) == 0) ? 33 : 35;
      endcase
    end
    if (forced_len != 0) len = forced_len;
    bad_pos = (kind == FK_BAD_BIT) ? $urandom_range(32, 1) : -1;
    for (k = 0; k < len; k++) begin
      if (k == 0) begin
        if (kind == FK_BAD_LEADER || (kind == FK_REPEAT && $urandom_range(1) == 0)) begin
          mark  = wild_ticks();
          space = wild_ticks();
        end else begin
          mark  = near_nom(c.leader_mark);
          space = near_nom(c.leader_space);
        end
      end else if (k <= 32 && k != bad_pos) begin
        one_bit = 1'($urandom_range(1));
        mark  = near_nom(one_bit ? c.one_mark : c.zero_mark);
        space = near_nom(one_bit ? c.one_space : c.zero_space);
      end else begin
        // stop symbol, symbols past the data bits, or the broken bit
        mark  = wild_ticks();
        space = wild_ticks();
      end
      send_symbol(mark, space, k == len - 1);
    end
  endtask

  // Short burst of junk symbols, closed by an end-of-frame so framing realigns.
  task automatic send_noise();
    int k, n;
    n = $urandom_range(4, 1);
    for (k = 0; k < n; k++)
      send_symbol(wild_ticks(), wild_ticks(), (k == n - 1) || ($urandom_range(2) == 0));
  endtask

  // Mostly well-formed frames with random content; the rest broken or noise.
  task automatic run_phase(int n_items);
    int start, r;
    start = sent_count;
    while (sent_count - start < n_items) begin
      r = $urandom_range(99);
      if (r < 50) send_frame(FK_CLEAN, 0);
      else if (r < 60) send_frame(FK_BAD_LEADER, 0);
      else if (r < 68) send_frame(FK_BAD_BIT, 0);
      else if (r < 80) send_frame(FK_REPEAT, 0);
      else if (r < 90) send_frame(FK_ODD_LENGTH, 0);
      else send_noise();
    end
  endtask

  initial begin : stimulus
    int p;
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items at reset config: field extremes and short frames.
    send_symbol(0, 0, 1'b1);                  // lone symbol: wrong count
    send_symbol(TICK_MAX, TICK_MAX, 1'b1);
    send_symbol(9000, 4500, 1'b0);            // repeat frame, good leader
    send_symbol(560, 560, 1'b1);
    send_symbol(0, TICK_MAX, 1'b0);           // repeat frame, leader off: still repeat
    send_symbol(TICK_MAX, 0, 1'b1);
    send_symbol(9000, 4500, 1'b0);            // three symbols: wrong count
    send_symbol(560, 1690, 1'b0);
    send_symbol(1, 1, 1'b1);
    send_symbol(21845, 10922, 1'b1);          // alternating bit patterns
    send_symbol(10922, 21845, 1'b1);

    // Valid, leader, bit and count statuses once at reset config, then a short random run.
    send_frame(FK_CLEAN, 0);
    send_frame(FK_BAD_LEADER, 0);
    send_frame(FK_BAD_BIT, 0);
    send_frame(FK_ODD_LENGTH, 70);            // count saturates at 63
    run_phase(10);
    drain_block();

    // Each phase: new config while idle, then its own idle/stall mix.
    for (p = 1; p < 8; p++) begin
      if (p == 5)
        write_reg(CFG_IDX_W'($urandom_range(255, REG_ONE_SPACE + 1)), 16'($urandom));
      case (p)
        1: load_config(0, RST_LEADER_MARK, RST_LEADER_SPACE, RST_ZERO_MARK,
                       RST_ZERO_SPACE, RST_ONE_MARK, RST_ONE_SPACE);  // empty windows
        2: load_config(MARGIN_MAX, 0, 0, 0, 0, 0, 0);                 // floor at zero
        3: load_config(MARGIN_MAX, TICK_MAX, TICK_MAX, TICK_MAX,
                       TICK_MAX, TICK_MAX, TICK_MAX);                 // top past range
        7: load_config(RST_MARGIN, RST_LEADER_MARK, RST_LEADER_SPACE, RST_ZERO_MARK,
                       RST_ZERO_SPACE, RST_ONE_MARK, RST_ONE_SPACE);
        default: load_config($urandom_range(600, 1), $urandom_range(TICK_MAX),
                             $urandom_range(TICK_MAX), $urandom_range(TICK_MAX),
                             $urandom_range(TICK_MAX), $urandom_range(TICK_MAX),
                             $urandom_range(TICK_MAX));
      endcase
      tx_idle  = (p % 2) != 0;
      rx_stall = ((p / 2) % 2) != 0;
      if (p == 6) begin
        // results pile up behind a long hold-off while the sender keeps going
        hold_req = 1'b1;
        repeat (12) send_frame(FK_REPEAT, 0);
      end
      run_phase(10);
      drain_block();
    end

    if (board.due_results.size() != 0)
      board.report($sformatf("%0d results never arrived", board.due_results.size()));
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
